// ===== design/asf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asf_pkg;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int REG_W    = 12;
   localparam int BYTE_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int CSR_IDX_W = 2;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd1;

   // Register reset values
   localparam logic [REG_W-1:0] GAIN_RESET   = 12'd1679;
   localparam logic [REG_W-1:0] OFFSET_RESET = 12'd142;

   // Frame characters
   localparam logic [BYTE_W-1:0] CHAR_STX   = 8'h02;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_ETX   = 8'h03;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

   // Depth of the digit queue between the front and the back
   localparam int QUEUE_DEPTH = 4;

   // Four decimal digits of one position, thousands first
   typedef struct packed {
      logic [DIGIT_W-1:0] thou;
      logic [DIGIT_W-1:0] hund;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] ones;
   } digits_type;

endpackage

`default_nettype wire

// ===== design/adc_sample_to_ascii_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts each 12-bit sample into an 8-byte ASCII frame (STX, d.ddd, CR, ETX)
// of the calibrated position (gain*sample)/4096 + offset, in thousandths.
// A sample is accepted whenever full is low. The serializer sends one byte per
// cycle while pop is held high, so the sustained sample rate is set by the eight
// bytes a frame takes on the result side. Up to QUEUE_DEPTH samples may be in
// flight before full rises. Calibration registers take effect on the next
// sample accepted after the write, though a new offset already applies to a
// sample accepted in the cycle of the write; writes to unknown indexes are ignored.

module adc_sample_to_ascii_frame #(
   parameter int QUEUE_DEPTH = asf_pkg::QUEUE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [asf_pkg::SAMPLE_W-1:0]   req_adc_sample,
   output logic                                empty,
   input  wire logic                           pop,
   output logic [asf_pkg::BYTE_W-1:0]          rsp_frame_byte,
   output logic                                rsp_frame_last,
   input  wire logic                           csr_wen,
   input  wire logic [asf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [asf_pkg::REG_W-1:0]      csr_wdata
);

   logic [asf_pkg::REG_W-1:0] gain_ff, offset_ff;
   logic                      take;
   logic                      q_push, q_pop, q_empty;
   asf_pkg::digits_type       q_in_data, q_out_data;
   logic                      out_valid;

   // Calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= asf_pkg::GAIN_RESET;
         offset_ff <= asf_pkg::OFFSET_RESET;
      end else if (csr_wen) begin
         if (csr_index == asf_pkg::CSR_GAIN) begin
            gain_ff <= csr_wdata;
         end else if (csr_index == asf_pkg::CSR_OFFSET) begin
            offset_ff <= csr_wdata;
         end
      end
   end

   assign take = push && !full;

   asf_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .sample (req_adc_sample),
      .gain   (gain_ff),
      .offset (offset_ff),
      .q_pop  (q_pop),
      .full   (full),
      .q_push (q_push),
      .q_data (q_in_data)
   );

   asf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   asf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .out_pop   (pop),
      .out_valid (out_valid),
      .out_byte  (rsp_frame_byte),
      .out_last  (rsp_frame_last)
   );

   assign empty = !out_valid;

   // Last byte of a frame is always ETX
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_last) |-> (rsp_frame_byte == asf_pkg::CHAR_ETX))
      else $error("frame end byte is not ETX");

   // A frame that follows a transferred last byte opens with STX
   assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && rsp_frame_last) |=> (empty || (rsp_frame_byte == asf_pkg::CHAR_STX)))
      else $error("frame does not start with STX");

   // The back never takes a frame from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("digit queue popped while empty");

endmodule

`default_nettype wire

// ===== design/asf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asf_queue #(
   parameter int DEPTH = asf_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire asf_pkg::digits_type push_data,
   input  wire logic                pop,
   output asf_pkg::digits_type      pop_data,
   output logic                     empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   asf_pkg::digits_type mem [DEPTH];

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   // Space is guaranteed by the front's credit count
   assign do_push = push;
   assign do_pop  = pop && (count_ff != '0);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem[rd_ptr_ff];
   assign empty    = (count_ff == '0);

endmodule

`default_nettype wire

// ===== design/asf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asf_front #(
   parameter int DEPTH = asf_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [asf_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic [asf_pkg::REG_W-1:0]     gain,
   input  wire logic [asf_pkg::REG_W-1:0]     offset,
   input  wire logic                          q_pop,
   output logic                               full,
   output logic                               q_push,
   output asf_pkg::digits_type                q_data
);

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int PROD_W = asf_pkg::SAMPLE_W + asf_pkg::REG_W;
   localparam int POS_W  = asf_pkg::REG_W + 1;
   localparam int DW     = asf_pkg::DIGIT_W;
   localparam int CMP_W  = POS_W + DW;

   // Largest decimal digit whose multiple of the place value does not exceed v
   function automatic logic [DW-1:0] lead_digit(input logic [POS_W-1:0] v,
                                                input logic [POS_W-1:0] unit);
      logic [DW-1:0] d;
      d = '0;
      for (int k = 1; k <= 9; k++) begin
         if (CMP_W'(v) >= CMP_W'(k) * CMP_W'(unit)) begin
            d = DW'(k);
         end
      end
      return d;
   endfunction

   // Pipeline registers
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [POS_W-1:0]  s2_pos_ff;
   logic [DW-1:0]     s3_thou_ff, s4_thou_ff, s4_hund_ff;
   logic [9:0]        s3_rem_ff;
   logic [6:0]        s4_rem_ff;
   logic [CW-1:0]     credit_ff, credit_in;

   logic [DW-1:0]     thou_in, hund_in, tens_in;
   logic [POS_W-1:0]  rem3_in, rem4_in, rem5_in;

   // Count items accepted and not yet taken by the back
   always_comb begin
      credit_in = credit_ff;
      if (take && !q_pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (q_pop && !take) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   assign full = (credit_ff == CW'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= take;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Split off thousands, hundreds and tens by constant compares
   always_comb begin
      thou_in = lead_digit(s2_pos_ff, POS_W'(1000));
      rem3_in = s2_pos_ff - POS_W'(thou_in) * POS_W'(1000);
      hund_in = lead_digit(POS_W'(s3_rem_ff), POS_W'(100));
      rem4_in = POS_W'(s3_rem_ff) - POS_W'(hund_in) * POS_W'(100);
      tens_in = lead_digit(POS_W'(s4_rem_ff), POS_W'(10));
      rem5_in = POS_W'(s4_rem_ff) - POS_W'(tens_in) * POS_W'(10);
   end

   // Scale, offset, then peel thousands and hundreds one place per stage; tens and ones are combinational at the output
   always_ff @(posedge clock) begin
      s1_prod_ff <= PROD_W'(gain) * PROD_W'(sample);
      s2_pos_ff  <= POS_W'(s1_prod_ff[PROD_W-1:asf_pkg::SAMPLE_W]) + POS_W'(offset);
      s3_thou_ff <= thou_in;
      s3_rem_ff  <= rem3_in[9:0];
      s4_thou_ff <= s3_thou_ff;
      s4_hund_ff <= hund_in;
      s4_rem_ff  <= rem4_in[6:0];
   end

   assign q_push      = s4_valid_ff;
   assign q_data.thou = s4_thou_ff;
   assign q_data.hund = s4_hund_ff;
   assign q_data.tens = tens_in;
   assign q_data.ones = rem5_in[DW-1:0];

endmodule

`default_nettype wire

// ===== design/asf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asf_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_empty,
   input  wire asf_pkg::digits_type         q_data,
   output logic                             q_pop,
   input  wire logic                        out_pop,
   output logic                             out_valid,
   output logic [asf_pkg::BYTE_W-1:0]       out_byte,
   output logic                             out_last
);

   localparam logic [2:0] IDX_STX  = 3'd0;
   localparam logic [2:0] IDX_THOU = 3'd1;
   localparam logic [2:0] IDX_DOT  = 3'd2;
   localparam logic [2:0] IDX_HUND = 3'd3;
   localparam logic [2:0] IDX_TENS = 3'd4;
   localparam logic [2:0] IDX_ONES = 3'd5;
   localparam logic [2:0] IDX_CR   = 3'd6;
   localparam logic [2:0] IDX_ETX  = 3'd7;

   asf_pkg::digits_type          digit_hold_ff, digit_hold_in;
   logic [2:0]                   byte_index_ff, byte_index_in;
   logic                         busy_ff, busy_in;
   logic                         valid_ff, valid_in;
   logic [asf_pkg::BYTE_W-1:0]   byte_ff, byte_in, cur_byte;
   logic                         last_ff, last_in;
   logic                         advance;

   // Pick the frame byte at the current index
   always_comb begin
      unique case (byte_index_ff)
         IDX_STX:  cur_byte = asf_pkg::CHAR_STX;
         IDX_THOU: cur_byte = asf_pkg::CHAR_ZERO | 8'(digit_hold_ff.thou);
         IDX_DOT:  cur_byte = asf_pkg::CHAR_DOT;
         IDX_HUND: cur_byte = asf_pkg::CHAR_ZERO | 8'(digit_hold_ff.hund);
         IDX_TENS: cur_byte = asf_pkg::CHAR_ZERO | 8'(digit_hold_ff.tens);
         IDX_ONES: cur_byte = asf_pkg::CHAR_ZERO | 8'(digit_hold_ff.ones);
         IDX_CR:   cur_byte = asf_pkg::CHAR_CR;
         IDX_ETX:  cur_byte = asf_pkg::CHAR_ETX;
         default:  cur_byte = asf_pkg::CHAR_STX;
      endcase
   end

   // Output register moves when empty or when its byte is transferred
   assign advance = !valid_ff || out_pop;
   assign q_pop   = advance && !busy_ff && !q_empty;

   always_comb begin
      digit_hold_in = digit_hold_ff;
      byte_index_in = byte_index_ff;
      busy_in       = busy_ff;
      valid_in      = valid_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      if (advance) begin
         if (busy_ff) begin
            valid_in      = 1'b1;
            byte_in       = cur_byte;
            last_in       = (byte_index_ff == IDX_ETX);
            byte_index_in = byte_index_ff + 1'b1;
            busy_in       = (byte_index_ff != IDX_ETX);
         end else if (!q_empty) begin
            // Load next frame and send its start byte at once
            digit_hold_in = q_data;
            valid_in      = 1'b1;
            byte_in       = asf_pkg::CHAR_STX;
            last_in       = 1'b0;
            byte_index_in = IDX_THOU;
            busy_in       = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_hold_ff <= '0;
         byte_index_ff <= IDX_STX;
         busy_ff       <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         digit_hold_ff <= digit_hold_in;
         byte_index_ff <= byte_index_in;
         busy_ff       <= busy_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== test/adc_sample_to_ascii_frame_tb.sv =====
`timescale 1ns / 1ps

module adc_sample_to_ascii_frame_tb;

   localparam int FRAME_LEN     = 8;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SEG_PER_PHASE = 4;
   localparam int ITEMS_PER_SEG = 19;

   // Indexes outside the register map; writes there must be dropped
   localparam logic [asf_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [asf_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [asf_pkg::BYTE_W-1:0] frame_byte;
      logic                       frame_last;
   } frame_beat_type;

   // Predicts the frame of each accepted sample and checks output bytes in order
   class frame_scoreboard;
      logic [asf_pkg::REG_W-1:0] gain;
      logic [asf_pkg::REG_W-1:0] offset;
      frame_beat_type            beats_due[$];
      int                        errors;

      function new();
         gain   = asf_pkg::GAIN_RESET;
         offset = asf_pkg::OFFSET_RESET;
         errors = 0;
      endfunction

      function void set_reg(logic [asf_pkg::CSR_IDX_W-1:0] idx,
                            logic [asf_pkg::REG_W-1:0] val);
         if (idx == asf_pkg::CSR_GAIN) begin
            gain = val;
         end else if (idx == asf_pkg::CSR_OFFSET) begin
            offset = val;
         end
      endfunction

      // Calibrate, split into digits and queue the eight frame bytes
      function void note_sample(logic [asf_pkg::SAMPLE_W-1:0] sample);
         int unsigned                pos;
         asf_pkg::digits_type        dg;
         frame_beat_type             beat;
         logic [asf_pkg::BYTE_W-1:0] frame [FRAME_LEN];
         pos     = (int'(gain) * int'(sample)) / 4096 + int'(offset);
         dg.thou = asf_pkg::DIGIT_W'((pos / 1000) % 10);
         dg.hund = asf_pkg::DIGIT_W'((pos / 100) % 10);
         dg.tens = asf_pkg::DIGIT_W'((pos / 10) % 10);
         dg.ones = asf_pkg::DIGIT_W'(pos % 10);
         frame[0] = asf_pkg::CHAR_STX;
         frame[1] = asf_pkg::CHAR_ZERO | asf_pkg::BYTE_W'(dg.thou);
         frame[2] = asf_pkg::CHAR_DOT;
         frame[3] = asf_pkg::CHAR_ZERO | asf_pkg::BYTE_W'(dg.hund);
         frame[4] = asf_pkg::CHAR_ZERO | asf_pkg::BYTE_W'(dg.tens);
         frame[5] = asf_pkg::CHAR_ZERO | asf_pkg::BYTE_W'(dg.ones);
         frame[6] = asf_pkg::CHAR_CR;
         frame[7] = asf_pkg::CHAR_ETX;
         for (int k = 0; k < FRAME_LEN; k++) begin
            beat.frame_byte = frame[k];
            beat.frame_last = (k == FRAME_LEN - 1);
            beats_due.push_back(beat);
         end
      endfunction

      function void check_byte(logic [asf_pkg::BYTE_W-1:0] got_byte, logic got_last);
         frame_beat_type want;
         if (beats_due.size() == 0) begin
            $error("frame_byte: expected none, got %02h", got_byte);
            errors++;
         end else begin
            want = beats_due.pop_front();
            if (got_byte !== want.frame_byte) begin
               $error("frame_byte: expected %02h, got %02h", want.frame_byte, got_byte);
               errors++;
            end
            if (got_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b", want.frame_last, got_last);
               errors++;
            end
         end
      endfunction

      function int pending();
         return beats_due.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic                          full;
   logic [asf_pkg::SAMPLE_W-1:0]  req_adc_sample = '0;
   logic                          empty;
   logic                          pop = 1'b0;
   logic [asf_pkg::BYTE_W-1:0]    rsp_frame_byte;
   logic                          rsp_frame_last;
   logic                          csr_wen = 1'b0;
   logic [asf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [asf_pkg::REG_W-1:0]     csr_wdata = '0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int cycle_count = 0;

   frame_scoreboard sb;

   adc_sample_to_ascii_frame dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_adc_sample (req_adc_sample),
      .empty          (empty),
      .pop            (pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Note accepted samples, check accepted bytes, randomize pop
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         sb.note_sample(req_adc_sample);
      end
      if (!reset && pop && !empty) begin
         sb.check_byte(rsp_frame_byte, rsp_frame_last);
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("adc_sample_to_ascii_frame: mismatch");
         $finish;
      end
   end

   // Offer one sample, idling first at the sender's rate; return after its transfer
   task automatic send_sample(input logic [asf_pkg::SAMPLE_W-1:0] sample);
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_adc_sample <= sample;
      do @(posedge clock); while (full);
   endtask

   // Drop push and wait until every queued byte has been checked
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [asf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [asf_pkg::REG_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [asf_pkg::REG_W-1:0] pick_reg_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return asf_pkg::REG_W'($urandom_range(4095));
      endcase
   endfunction

   function automatic logic [asf_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(19))
         0:       return '0;
         1:       return '1;
         2:       return asf_pkg::SAMPLE_W'(1) << $urandom_range(asf_pkg::SAMPLE_W - 1);
         default: return asf_pkg::SAMPLE_W'($urandom_range(4095));
      endcase
   endfunction

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset calibration, then the range extremes
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_sample('0);
      send_sample('1);
      send_sample(12'd1);
      send_sample(12'd2048);
      wait_drained();

      // Largest position: full gain and offset
      write_reg(asf_pkg::CSR_GAIN, '1);
      write_reg(asf_pkg::CSR_OFFSET, '1);
      send_sample('1);
      send_sample('0);
      send_sample(12'h555);
      send_sample(12'hAAA);
      wait_drained();

      // Zero calibration; spare indexes must leave it untouched
      write_reg(asf_pkg::CSR_GAIN, '0);
      write_reg(asf_pkg::CSR_OFFSET, '0);
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, 12'hA5A);
      send_sample('1);
      send_sample(12'd1234);
      wait_drained();

      // Digit carries around 999 and 1000
      write_reg(asf_pkg::CSR_GAIN, 12'd4095);
      write_reg(asf_pkg::CSR_OFFSET, 12'd999);
      send_sample(12'd0);
      send_sample(12'd1);
      send_sample(12'd2);
      wait_drained();
      write_reg(CSR_SPARE_LO, 12'd0);
      send_sample(12'd4095);
      wait_drained();

      // Random phases: slow receiver, slow sender, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 15;
               rx_idle_pct = 66;
            end
            1: begin
               tx_idle_pct = 66;
               rx_idle_pct = 15;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < SEG_PER_PHASE; seg++) begin
            wait_drained();
            write_reg(asf_pkg::CSR_GAIN, pick_reg_value());
            write_reg(asf_pkg::CSR_OFFSET, pick_reg_value());
            if ($urandom_range(3) == 0) begin
               write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, pick_reg_value());
            end
            for (int n = 0; n < ITEMS_PER_SEG; n++) begin
               send_sample(pick_sample());
            end
         end
      end

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("adc_sample_to_ascii_frame: match");
      end else begin
         $display("adc_sample_to_ascii_frame: mismatch");
      end
      $finish;
   end

endmodule
